// ===== rtl/psw_pkg.sv =====
// Shared types and constants of the two-coordinate particle swarm step engine.
package psw_pkg;

    localparam int SWARM_SIZE_DEF = 16;
    localparam int COORD_W        = 32;
    localparam int GAIN_W         = 16;
    localparam int FRAC_W         = 16;
    localparam int CFG_IDX_W      = 3;

    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_EVAL   = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INERTIA   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COGNITIVE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SOCIAL    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXIMIZE  = 3'd7;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [3:0]               particle;
        logic signed [COORD_W-1:0] cost;
        logic                     first_sweep;
        logic [FRAC_W-1:0]        vel_frac_x;
        logic [FRAC_W-1:0]        vel_frac_y;
        logic [FRAC_W-1:0]        pos_frac_x;
        logic [FRAC_W-1:0]        pos_frac_y;
        logic [FRAC_W-1:0]        cog_rand;
        logic [FRAC_W-1:0]        soc_rand;
    } t_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] part_x;
        logic signed [COORD_W-1:0] part_y;
        logic signed [COORD_W-1:0] best_x;
        logic signed [COORD_W-1:0] best_y;
        logic signed [COORD_W-1:0] best_cost;
        logic                      best_valid;
    } t_result;

endpackage

// ===== rtl/psw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psw_ram #(
    parameter int WIDTH = psw_pkg::COORD_W,
    parameter int DEPTH = psw_pkg::SWARM_SIZE_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/particle_swarm_step_2d.sv =====
// Top level of the two-coordinate particle swarm step engine.
// Each item runs alone through a step sequencer around one shared 34x17 signed
// multiplier; the block raises o_stall from acceptance until the result is in
// the output register. An update issues eight multiplies back to back, then
// saturation, clamping and the store write; an init scales the two position
// fractions into the ranges and writes the stores; an evaluate, an unknown
// opcode or a particle beyond the swarm passes through the execute state
// without multiplies. The particle stores have a registered read, which adds
// the S_READ state to every item. A finished result waits in the output
// register while the next item is accepted.
module particle_swarm_step_2d #(
    parameter int SWARM_SIZE = psw_pkg::SWARM_SIZE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  psw_pkg::t_item                        i_item,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output psw_pkg::t_result                      o_result,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [psw_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [psw_pkg::COORD_W-1:0]           i_cfg_data
);

    localparam int AW = (SWARM_SIZE > 1) ? $clog2(SWARM_SIZE) : 1;
    localparam int CW = psw_pkg::COORD_W;
    localparam int GW = psw_pkg::GAIN_W;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_DONE} t_state;

    t_state                r_state;
    logic [3:0]            r_step;
    psw_pkg::t_item        r_item;
    logic [AW-1:0]         r_addr;
    logic                  r_inrange;
    logic signed [CW-1:0]  r_min_x, r_max_x, r_min_y, r_max_y;
    logic [GW-1:0]         r_inertia, r_cognitive, r_social;
    logic                  r_maximize;
    logic signed [CW-1:0]  r_gbx, r_gby, r_gbc;
    logic                  r_seen;
    logic [GW-1:0]         r_rp, r_rg;
    logic signed [50:0]    r_prod;
    logic signed [39:0]    r_acc;
    logic signed [CW-1:0]  r_nvx, r_nvy, r_npx, r_npy;
    logic                  r_ovalid;
    psw_pkg::t_result      r_result;

    logic [2*CW-1:0]       pos_rd, vel_rd, pbxy_rd, pos_wd, vel_wd, pbxy_wd;
    logic [CW-1:0]         pbc_rd;
    logic                  pos_we, vel_we, pbxy_we, pbc_we;
    logic signed [CW-1:0]  px, py, vx, vy, pbx, pby, pbc;
    logic signed [33:0]    mul_a;
    logic signed [16:0]    mul_b;
    logic signed [50:0]    prod;
    logic signed [39:0]    term;
    logic signed [CW-1:0]  seed_lo, seed_pos, seed_vx, seed_vy;
    logic                  is_init, is_eval, is_upd, accept, pb_take, gb_take;

    function automatic logic signed [CW-1:0] sat_acc(input logic signed [39:0] v);
        logic signed [CW-1:0] q;
        if (v[39:31] == {9{v[39]}}) begin
            q = v[31:0];
        end else if (v[39]) begin
            q = 32'sh8000_0000;
        end else begin
            q = 32'sh7fff_ffff;
        end
        return q;
    endfunction

    function automatic logic signed [CW-1:0] move_pos(
        input logic signed [CW-1:0] p,
        input logic signed [CW-1:0] v,
        input logic signed [CW-1:0] lo,
        input logic signed [CW-1:0] hi
    );
        logic signed [CW:0]   s;
        logic signed [CW-1:0] q;
        s = {p[CW-1], p} + {v[CW-1], v};
        if (s[CW] != s[CW-1]) begin
            q = s[CW] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            q = s[CW-1:0];
        end
        if (q < lo) begin
            q = lo;
        end else if (q > hi) begin
            q = hi;
        end
        return q;
    endfunction

    function automatic logic better(
        input logic                 maximize,
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        return maximize ? (a > b) : (a < b);
    endfunction

    psw_ram #(.WIDTH(2*CW), .DEPTH(SWARM_SIZE), .AW(AW)) u_pos_ram (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(r_addr), .i_wdata(pos_wd),
        .i_raddr(r_addr), .o_rdata(pos_rd)
    );
    psw_ram #(.WIDTH(2*CW), .DEPTH(SWARM_SIZE), .AW(AW)) u_vel_ram (
        .i_clk(i_clk), .i_we(vel_we), .i_waddr(r_addr), .i_wdata(vel_wd),
        .i_raddr(r_addr), .o_rdata(vel_rd)
    );
    psw_ram #(.WIDTH(2*CW), .DEPTH(SWARM_SIZE), .AW(AW)) u_pbxy_ram (
        .i_clk(i_clk), .i_we(pbxy_we), .i_waddr(r_addr), .i_wdata(pbxy_wd),
        .i_raddr(r_addr), .o_rdata(pbxy_rd)
    );
    psw_ram #(.WIDTH(CW), .DEPTH(SWARM_SIZE), .AW(AW)) u_pbc_ram (
        .i_clk(i_clk), .i_we(pbc_we), .i_waddr(r_addr), .i_wdata(r_item.cost),
        .i_raddr(r_addr), .o_rdata(pbc_rd)
    );

    assign px  = pos_rd[CW-1:0];
    assign py  = pos_rd[2*CW-1:CW];
    assign vx  = vel_rd[CW-1:0];
    assign vy  = vel_rd[2*CW-1:CW];
    assign pbx = pbxy_rd[CW-1:0];
    assign pby = pbxy_rd[2*CW-1:CW];
    assign pbc = pbc_rd;

    assign is_init = r_inrange && (r_item.opcode == psw_pkg::OP_INIT);
    assign is_eval = r_inrange && (r_item.opcode == psw_pkg::OP_EVAL);
    assign is_upd  = r_inrange && (r_item.opcode == psw_pkg::OP_UPDATE);

    assign pb_take = r_item.first_sweep || better(r_maximize, r_item.cost, pbc);
    assign gb_take = !r_seen || better(r_maximize, r_item.cost, r_gbc);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (is_init) begin
            case (r_step)
                4'd0: begin
                    mul_a = {r_max_x[CW-1], r_max_x[CW-1], r_max_x}
                          - {r_min_x[CW-1], r_min_x[CW-1], r_min_x};
                    mul_b = {1'b0, r_item.pos_frac_x};
                end
                default: begin
                    mul_a = {r_max_y[CW-1], r_max_y[CW-1], r_max_y}
                          - {r_min_y[CW-1], r_min_y[CW-1], r_min_y};
                    mul_b = {1'b0, r_item.pos_frac_y};
                end
            endcase
        end else begin
            case (r_step)
                4'd0: begin
                    mul_a = {18'b0, r_cognitive};
                    mul_b = {1'b0, r_item.cog_rand};
                end
                4'd1: begin
                    mul_a = {18'b0, r_social};
                    mul_b = {1'b0, r_item.soc_rand};
                end
                4'd2: begin
                    mul_a = {{2{vx[CW-1]}}, vx};
                    mul_b = {1'b0, r_inertia};
                end
                4'd3: begin
                    mul_a = {{2{pbx[CW-1]}}, pbx} - {{2{px[CW-1]}}, px};
                    mul_b = {1'b0, r_rp};
                end
                4'd4: begin
                    mul_a = {{2{r_gbx[CW-1]}}, r_gbx} - {{2{px[CW-1]}}, px};
                    mul_b = {1'b0, r_rg};
                end
                4'd5: begin
                    mul_a = {{2{vy[CW-1]}}, vy};
                    mul_b = {1'b0, r_inertia};
                end
                4'd6: begin
                    mul_a = {{2{pby[CW-1]}}, pby} - {{2{py[CW-1]}}, py};
                    mul_b = {1'b0, r_rp};
                end
                4'd7: begin
                    mul_a = {{2{r_gby[CW-1]}}, r_gby} - {{2{py[CW-1]}}, py};
                    mul_b = {1'b0, r_rg};
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign prod     = mul_a * mul_b;
    assign term     = {{3{r_prod[50]}}, r_prod[50:14]};
    assign seed_lo  = (r_step == 4'd1) ? r_min_x : r_min_y;
    assign seed_pos = seed_lo + r_prod[47:16];
    assign seed_vx  = {15'b0, r_item.vel_frac_x, 1'b0} - 32'sh0001_0000;
    assign seed_vy  = {15'b0, r_item.vel_frac_y, 1'b0} - 32'sh0001_0000;

    always_comb begin
        pos_we  = 1'b0;
        vel_we  = 1'b0;
        pbxy_we = 1'b0;
        pbc_we  = 1'b0;
        pos_wd  = {r_npy, r_npx};
        vel_wd  = {r_nvy, r_nvx};
        pbxy_wd = {r_npy, r_npx};
        if (r_state == S_EXEC) begin
            if (is_init && r_step == 4'd3) begin
                pos_we  = 1'b1;
                vel_we  = 1'b1;
                pbxy_we = 1'b1;
                vel_wd  = {seed_vy, seed_vx};
            end
            if (is_upd && r_step == 4'd11) begin
                pos_we = 1'b1;
                vel_we = 1'b1;
            end
            if (is_eval && r_step == 4'd0 && pb_take) begin
                pbxy_we = 1'b1;
                pbc_we  = 1'b1;
                pbxy_wd = pos_rd;
            end
        end
    end

    assign accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_ovalid    <= 1'b0;
            r_min_x     <= -32'sd327680;
            r_max_x     <= 32'sd327680;
            r_min_y     <= -32'sd327680;
            r_max_y     <= 32'sd327680;
            r_inertia   <= 16'd11469;
            r_cognitive <= 16'd24576;
            r_social    <= 16'd24576;
            r_maximize  <= 1'b0;
            r_gbx       <= '0;
            r_gby       <= '0;
            r_gbc       <= '0;
            r_seen      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    psw_pkg::CFG_MIN_X:     r_min_x     <= i_cfg_data;
                    psw_pkg::CFG_MAX_X:     r_max_x     <= i_cfg_data;
                    psw_pkg::CFG_MIN_Y:     r_min_y     <= i_cfg_data;
                    psw_pkg::CFG_MAX_Y:     r_max_y     <= i_cfg_data;
                    psw_pkg::CFG_INERTIA:   r_inertia   <= i_cfg_data[GW-1:0];
                    psw_pkg::CFG_COGNITIVE: r_cognitive <= i_cfg_data[GW-1:0];
                    psw_pkg::CFG_SOCIAL:    r_social    <= i_cfg_data[GW-1:0];
                    psw_pkg::CFG_MAXIMIZE:  r_maximize  <= i_cfg_data[0];
                    default:                r_maximize  <= r_maximize;
                endcase
            end

            if (r_ovalid && !i_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end

            r_prod <= prod;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item    <= i_item;
                        r_addr    <= AW'(i_item.particle);
                        r_inrange <= int'(i_item.particle) < SWARM_SIZE;
                        r_step    <= '0;
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_step <= r_step + 4'd1;
                    if (is_init) begin
                        case (r_step)
                            4'd1: r_npx <= seed_pos;
                            4'd2: r_npy <= seed_pos;
                            4'd3: begin
                                r_seen  <= 1'b0;
                                r_state <= S_DONE;
                            end
                            default: r_npx <= r_npx;
                        endcase
                    end else if (is_upd) begin
                        case (r_step)
                            4'd1: r_rp <= r_prod[31:16];
                            4'd2: r_rg <= r_prod[31:16];
                            4'd3: r_acc <= term;
                            4'd4: r_acc <= r_acc + term;
                            4'd5: r_acc <= r_acc + term;
                            4'd6: begin
                                r_nvx <= sat_acc(r_acc);
                                r_acc <= term;
                            end
                            4'd7: begin
                                r_acc <= r_acc + term;
                                r_npx <= move_pos(px, r_nvx, r_min_x, r_max_x);
                            end
                            4'd8: r_acc <= r_acc + term;
                            4'd9: r_nvy <= sat_acc(r_acc);
                            4'd10: r_npy <= move_pos(py, r_nvy, r_min_y, r_max_y);
                            4'd11: r_state <= S_DONE;
                            default: r_acc <= r_acc;
                        endcase
                    end else begin
                        r_npx   <= r_inrange ? px : '0;
                        r_npy   <= r_inrange ? py : '0;
                        r_state <= S_DONE;
                        if (is_eval && pb_take && gb_take) begin
                            r_gbc  <= r_item.cost;
                            r_gbx  <= px;
                            r_gby  <= py;
                            r_seen <= 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_result.part_x     <= r_npx;
                        r_result.part_y     <= r_npy;
                        r_result.best_x     <= r_gbx;
                        r_result.best_y     <= r_gby;
                        r_result.best_cost  <= r_gbc;
                        r_result.best_valid <= r_seen;
                        r_ovalid            <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== rtl/psw_checker.sv =====
// Port-level checker for the particle swarm step engine and its bind.
module psw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input psw_pkg::t_result              o_result,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready
);

    logic in_acc;
    logic cfg_acc;

    assign in_acc  = i_valid && !o_stall;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("stalled result changed or dropped");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("block took no time to work on an accepted item");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_valid))
        else $error("result appeared in the cycle after acceptance");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset left the block busy or holding a result");

    a_cfg_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> cfg_acc)
        else $error("configuration write was not taken");

endmodule

bind particle_swarm_step_2d psw_checker u_psw_checker (.*);
